@@ design/qao_pkg.sv @@
package qao_pkg;

    // pulse counter width and CORDIC rotation count
    localparam int COUNT_BITS      = 32;
    localparam int TRIG_ITERATIONS = 24;
    localparam int ITER_W          = $clog2(TRIG_ITERATIONS);

    // stream widths
    localparam int IN_W  = 40;
    localparam int OUT_W = 224;

    // fixed-point constants
    localparam logic signed [33:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30        = 34'sd1073741824;
    localparam logic [31:0]        STEER_TO_ANGLE = 32'd2734261102;
    localparam logic [33:0]        RATE_TO_ANGLE  = 34'd11468322278;
    localparam logic [30:0]        MAG31          = 31'h7FFF_FFFF;
    localparam logic [32:0]        MAG33          = 33'h1_FFFF_FFFF;
    localparam logic [19:0]        US_PER_S       = 20'd1000000;

    // configuration reset values
    localparam logic [31:0] MPT_RESET = 32'd1218121;
    localparam logic [31:0] IWB_RESET = 32'd122016116;
    localparam logic [15:0] THR_RESET = 16'd66;

    typedef enum logic [1:0] {
        CFG_MPT = 2'd0,
        CFG_IWB = 2'd1,
        CFG_THR = 2'd2
    } cfg_idx_t;

    // one odometry tick as handed from front to back
    typedef struct packed {
        logic [30:0]        dmag;
        logic               neg;
        logic signed [15:0] steer;
        logic [19:0]        us;
    } tick_job_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_res_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } cordic_res_t;

    typedef enum logic [5:0] {
        ST_IDLE, ST_MDIST, ST_DIST, ST_MV, ST_DV_GO, ST_DV_WAIT,
        ST_MSTEER, ST_CS_GO, ST_CS_WAIT, ST_MT, ST_T, ST_MNUM,
        ST_DW_GO, ST_DW_WAIT, ST_MWD, ST_MWL, ST_MWH, ST_DTH,
        ST_C0_GO, ST_C0_WAIT, ST_C1_GO, ST_C1_WAIT,
        ST_MAX, ST_DX_GO, ST_DX_WAIT, ST_MAY, ST_DY_GO, ST_DY_WAIT,
        ST_SX, ST_SY, ST_SYD, ST_POSE, ST_Q_GO, ST_Q_WAIT, ST_OUT
    } back_state_t;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

@@ design/qao_front.sv @@
module qao_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                mode,
    input  logic                enc_a,
    input  logic                enc_b,
    input  logic signed [15:0]  steer_in,
    input  logic [19:0]         tick_interval_us,
    input  logic                q_full,
    output logic                q_push,
    output qao_pkg::tick_job_t  q_job
);
    import qao_pkg::*;

    logic [COUNT_BITS-1:0] pulse_total_reg, pulse_total_next;
    logic [COUNT_BITS-1:0] pulse_last_reg;
    logic                  last_a_reg, primed_reg;
    logic                  beat;
    logic [COUNT_BITS-1:0] raw, mag;
    logic [64:0]           mag_ext;

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;
    assign q_push   = beat && mode;

    // pulses since the last tick, as sign and clamped magnitude
    always_comb begin
        raw     = pulse_total_reg - pulse_last_reg;
        mag     = raw[COUNT_BITS-1] ? (~raw + 1'b1) : raw;
        mag_ext = 65'(mag);
        q_job.neg   = raw[COUNT_BITS-1];
        q_job.dmag  = (mag_ext > 65'(MAG31)) ? MAG31 : mag_ext[30:0];
        q_job.steer = steer_in;
        q_job.us    = (tick_interval_us == '0) ? 20'd1 : tick_interval_us;
    end

    // quadrature step on each change of channel A
    always_comb begin
        pulse_total_next = pulse_total_reg;
        if (primed_reg && (enc_a != last_a_reg)) begin
            pulse_total_next = (enc_a != enc_b) ? pulse_total_reg + 1'b1
                                                : pulse_total_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_total_reg <= '0;
            pulse_last_reg  <= '0;
            last_a_reg      <= 1'b0;
            primed_reg      <= 1'b0;
        end else if (beat) begin
            if (mode) begin
                pulse_last_reg <= pulse_total_reg;
            end else begin
                pulse_total_reg <= pulse_total_next;
                last_a_reg      <= enc_a;
                primed_reg      <= 1'b1;
            end
        end
    end

endmodule

@@ design/qao_queue.sv @@
module qao_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  qao_pkg::tick_job_t din,
    output logic               full,
    input  logic               pop,
    output logic               avail,
    output qao_pkg::tick_job_t dout
);
    import qao_pkg::*;

    tick_job_t  mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign dout  = mem_reg[rd_ptr_reg];

    // payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end

endmodule

@@ design/qao_div.sv @@
module qao_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       num,
    input  logic [63:0]       den,
    output qao_pkg::div_res_t res
);
    import qao_pkg::*;

    logic [64:0] rem_reg;
    logic [63:0] quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic        ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg[63:0], quo_reg[63]};
    assign ge    = (trial >= {1'b0, den_reg});

    assign res.done = done_reg;
    assign res.quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ design/qao_cordic.sv @@
module qao_cordic (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [31:0]          angle,
    output qao_pkg::cordic_res_t res
);
    import qao_pkg::*;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic [ITER_W-1:0]  i_reg;
    logic               busy_reg, done_reg;
    logic               flip_in;
    logic signed [33:0] xs, ys, ta, xo, yo;

    function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
        logic signed [33:0] r;
        if (v > ONE_Q30)       r = ONE_Q30;
        else if (v < -ONE_Q30) r = -ONE_Q30;
        else                   r = v;
        return r;
    endfunction

    // fold angles of the left half plane onto the right
    assign flip_in = angle[31] ^ angle[30];

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign ta = 34'(atan_lut(5'(i_reg)));

    always_comb begin
        xo = clamp30(x_reg);
        yo = clamp30(y_reg);
        if (flip_reg) begin
            xo = -xo;
            yo = -yo;
        end
        res.done = done_reg;
        res.c    = xo[31:0];
        res.s    = yo[31:0];
    end

    // one rotation per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= 34'($signed({angle[31] ^ flip_in, angle[30:0]}));
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ta;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ta;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
            end else if (busy_reg) begin
                if (i_reg == ITER_W'(TRIG_ITERATIONS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

endmodule

@@ design/qao_back.sv @@
module qao_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [31:0]            cfg_wdata,
    input  logic                   q_avail,
    input  qao_pkg::tick_job_t     q_job,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [qao_pkg::OUT_W-1:0] m_tdata
);
    import qao_pkg::*;

    back_state_t        state_reg, state_next;
    logic [31:0]        mpt_reg, iwb_reg;
    logic [15:0]        thr_reg;
    tick_job_t          job_reg;
    logic               neg_reg;
    logic [30:0]        dist_reg, vmag_reg, wmag_reg;
    logic [32:0]        t_reg;
    logic signed [31:0] sc_reg, ss_reg, c0_reg, s0_reg, c1_reg, s1_reg;
    logic signed [31:0] qw_reg, qz_reg;
    logic [18:0]        wd_hi_reg;
    logic [65:0]        plo_reg;
    logic [31:0]        dth_reg, heading_reg;
    logic signed [63:0] dx_reg, dy_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg;
    logic signed [69:0] prod_reg;
    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;

    // sequencer outputs
    logic signed [34:0] mul_a, mul_b;
    logic               div_start, cor_start, out_load;
    logic [63:0]        div_num, div_den;
    logic [31:0]        cor_angle;
    div_res_t           div_res;
    cordic_res_t        cor_res;

    // derived values
    logic [63:0]        rnd16, rnd24, dist_den;
    logic [47:0]        dist_full;
    logic [39:0]        t_full;
    logic [30:0]        dist_c, vmag_c, wmag_c;
    logic [32:0]        t_c;
    logic [16:0]        steer_mag;
    logic [31:0]        am;
    logic [31:0]        ss_abs, sc_abs;
    logic               wneg;
    logic signed [31:0] dist_s, v_s, w_s;
    logic signed [32:0] diff_s, diff_c;
    logic [31:0]        dmag_s, dmag_c;
    logic [71:0]        full72;
    logic [31:0]        dth_raw;
    logic signed [69:0] rnd29, str_val;
    logic signed [63:0] qs;
    logic signed [65:0] sum_x, sum_y;
    logic signed [31:0] sat_x, sat_y;

    qao_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    qao_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .angle   (cor_angle),
        .res     (cor_res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // rounding, clamping and sign handling around the shared units
    always_comb begin
        rnd16     = prod_reg[63:0] + 64'd32768;
        dist_full = rnd16[63:16];
        dist_c    = (dist_full > 48'(MAG31)) ? MAG31 : dist_full[30:0];
        vmag_c    = (div_res.quo > 64'(MAG31)) ? MAG31 : div_res.quo[30:0];
        wmag_c    = vmag_c;
        rnd24     = prod_reg[63:0] + 64'h80_0000;
        t_full    = rnd24[63:24];
        t_c       = (t_full > 40'(MAG33)) ? MAG33 : t_full[32:0];
        steer_mag = job_reg.steer[15] ? (17'd0 - 17'(job_reg.steer))
                                      : 17'(job_reg.steer);
        am        = rnd16[47:16];
        ss_abs    = ss_reg[31] ? (32'd0 - ss_reg) : ss_reg;
        sc_abs    = sc_reg[31] ? (32'd0 - sc_reg) : sc_reg;
        wneg      = (wmag_reg != '0) && (neg_reg ^ ss_reg[31] ^ sc_reg[31]);
        dist_s    = neg_reg ? -$signed({1'b0, dist_reg}) : $signed({1'b0, dist_reg});
        v_s       = neg_reg ? -$signed({1'b0, vmag_reg}) : $signed({1'b0, vmag_reg});
        w_s       = wneg ? -$signed({1'b0, wmag_reg}) : $signed({1'b0, wmag_reg});
        diff_s    = 33'(s1_reg) - 33'(s0_reg);
        diff_c    = 33'(c1_reg) - 33'(c0_reg);
        dmag_s    = diff_s[32] ? 32'(-diff_s) : diff_s[31:0];
        dmag_c    = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
        dist_den  = {19'd0, wmag_reg, 14'd0};
        full72    = {prod_reg[39:0], 32'd0} + {6'd0, plo_reg};
        dth_raw   = full72[71:40];
        rnd29     = prod_reg + 70'sd536870912;
        str_val   = rnd29 >>> 30;
        qs        = $signed(div_res.quo);
        sum_x     = 66'(pose_x_reg) + 66'(dx_reg);
        sum_y     = 66'(pose_y_reg) + 66'(dy_reg);
        if (sum_x > 66'sd2147483647)       sat_x = 32'sh7FFF_FFFF;
        else if (sum_x < -66'sd2147483648) sat_x = 32'sh8000_0000;
        else                               sat_x = sum_x[31:0];
        if (sum_y > 66'sd2147483647)       sat_y = 32'sh7FFF_FFFF;
        else if (sum_y < -66'sd2147483648) sat_y = 32'sh8000_0000;
        else                               sat_y = sum_y[31:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (q_avail) state_next = ST_MDIST;
            ST_MDIST:   state_next = ST_DIST;
            ST_DIST:    state_next = ST_MV;
            ST_MV:      state_next = ST_DV_GO;
            ST_DV_GO:   state_next = ST_DV_WAIT;
            ST_DV_WAIT: if (div_res.done) state_next = ST_MSTEER;
            ST_MSTEER:  state_next = ST_CS_GO;
            ST_CS_GO:   state_next = ST_CS_WAIT;
            ST_CS_WAIT: if (cor_res.done) state_next = ST_MT;
            ST_MT:      state_next = ST_T;
            ST_T:       state_next = ST_MNUM;
            ST_MNUM:    state_next = ST_DW_GO;
            ST_DW_GO:   state_next = (sc_reg == '0) ? ST_MWD : ST_DW_WAIT;
            ST_DW_WAIT: if (div_res.done) state_next = ST_MWD;
            ST_MWD:     state_next = ST_MWL;
            ST_MWL:     state_next = ST_MWH;
            ST_MWH:     state_next = ST_DTH;
            ST_DTH:     state_next = ST_C0_GO;
            ST_C0_GO:   state_next = ST_C0_WAIT;
            ST_C0_WAIT: begin
                if (cor_res.done) begin
                    state_next = (wmag_reg > 31'(thr_reg)) ? ST_C1_GO : ST_SX;
                end
            end
            ST_C1_GO:   state_next = ST_C1_WAIT;
            ST_C1_WAIT: if (cor_res.done) state_next = ST_MAX;
            ST_MAX:     state_next = ST_DX_GO;
            ST_DX_GO:   state_next = ST_DX_WAIT;
            ST_DX_WAIT: if (div_res.done) state_next = ST_MAY;
            ST_MAY:     state_next = ST_DY_GO;
            ST_DY_GO:   state_next = ST_DY_WAIT;
            ST_DY_WAIT: if (div_res.done) state_next = ST_POSE;
            ST_SX:      state_next = ST_SY;
            ST_SY:      state_next = ST_SYD;
            ST_SYD:     state_next = ST_POSE;
            ST_POSE:    state_next = ST_Q_GO;
            ST_Q_GO:    state_next = ST_Q_WAIT;
            ST_Q_WAIT:  if (cor_res.done) state_next = ST_OUT;
            ST_OUT:     if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit operands and strobes
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        cor_start = 1'b0;
        cor_angle = '0;
        q_pop     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   q_pop = q_avail;
            ST_MDIST: begin
                mul_a = 35'(job_reg.dmag);
                mul_b = 35'(mpt_reg);
            end
            ST_MV: begin
                mul_a = 35'(dist_reg);
                mul_b = 35'(US_PER_S);
            end
            ST_DV_GO: begin
                div_start = 1'b1;
                div_num   = prod_reg[63:0] + 64'(job_reg.us[19:1]);
                div_den   = 64'(job_reg.us);
            end
            ST_MSTEER: begin
                mul_a = 35'(steer_mag);
                mul_b = 35'(STEER_TO_ANGLE);
            end
            ST_CS_GO: begin
                cor_start = 1'b1;
                cor_angle = job_reg.steer[15] ? (32'd0 - am) : am;
            end
            ST_MT: begin
                mul_a = 35'(vmag_reg);
                mul_b = 35'(iwb_reg);
            end
            ST_MNUM: begin
                mul_a = 35'(t_reg);
                mul_b = 35'(ss_abs);
            end
            ST_DW_GO: begin
                div_start = (sc_reg != '0);
                div_num   = prod_reg[63:0] + 64'(sc_abs[31:1]);
                div_den   = 64'(sc_abs);
            end
            ST_MWD: begin
                mul_a = 35'(wmag_reg);
                mul_b = 35'(job_reg.us);
            end
            ST_MWL: begin
                mul_a = 35'(prod_reg[31:0]);
                mul_b = 35'(RATE_TO_ANGLE);
            end
            ST_MWH: begin
                mul_a = 35'(wd_hi_reg);
                mul_b = 35'(RATE_TO_ANGLE);
            end
            ST_C0_GO: begin
                cor_start = 1'b1;
                cor_angle = heading_reg;
            end
            ST_C1_GO: begin
                cor_start = 1'b1;
                cor_angle = heading_reg + dth_reg;
            end
            ST_MAX: begin
                mul_a = 35'(vmag_reg);
                mul_b = 35'(dmag_s);
            end
            ST_MAY: begin
                mul_a = 35'(vmag_reg);
                mul_b = 35'(dmag_c);
            end
            ST_DX_GO, ST_DY_GO: begin
                div_start = 1'b1;
                div_num   = prod_reg[63:0] + {1'b0, dist_den[63:1]};
                div_den   = dist_den;
            end
            ST_SX: begin
                mul_a = 35'(dist_s);
                mul_b = 35'(c0_reg);
            end
            ST_SY: begin
                mul_a = 35'(dist_s);
                mul_b = 35'(s0_reg);
            end
            ST_Q_GO: begin
                cor_start = 1'b1;
                cor_angle = {1'b0, heading_reg[31:1]};
            end
            ST_OUT:    out_load = !m_valid_reg || m_tready;
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:    if (q_avail) job_reg <= q_job;
            ST_DIST: begin
                dist_reg <= dist_c;
                neg_reg  <= job_reg.neg && (dist_c != '0);
            end
            ST_DV_WAIT: if (div_res.done) vmag_reg <= vmag_c;
            ST_CS_WAIT: begin
                if (cor_res.done) begin
                    sc_reg <= cor_res.c;
                    ss_reg <= cor_res.s;
                end
            end
            ST_T:       t_reg <= t_c;
            ST_DW_GO: begin
                if (sc_reg == '0) wmag_reg <= (prod_reg[63:0] == '0) ? '0 : MAG31;
            end
            ST_DW_WAIT: if (div_res.done) wmag_reg <= wmag_c;
            ST_MWL:     wd_hi_reg <= prod_reg[50:32];
            ST_MWH:     plo_reg <= prod_reg[65:0];
            ST_DTH:     dth_reg <= wneg ? (32'd0 - dth_raw) : dth_raw;
            ST_C0_WAIT: begin
                if (cor_res.done) begin
                    c0_reg <= cor_res.c;
                    s0_reg <= cor_res.s;
                end
            end
            ST_C1_WAIT: begin
                if (cor_res.done) begin
                    c1_reg <= cor_res.c;
                    s1_reg <= cor_res.s;
                end
            end
            ST_DX_WAIT: begin
                if (div_res.done) dx_reg <= (neg_reg ^ diff_s[32] ^ wneg) ? -qs : qs;
            end
            ST_DY_WAIT: begin
                if (div_res.done) dy_reg <= (neg_reg ^ diff_c[32] ^ wneg) ? qs : -qs;
            end
            ST_SY:      dx_reg <= str_val[63:0];
            ST_SYD:     dy_reg <= str_val[63:0];
            ST_Q_WAIT: begin
                if (cor_res.done) begin
                    qw_reg <= cor_res.c;
                    qz_reg <= cor_res.s;
                end
            end
            default: begin
                dth_reg <= dth_reg;
            end
        endcase
        if (out_load) begin
            m_data_reg <= {w_s, v_s, qw_reg, qz_reg, heading_reg, pose_y_reg, pose_x_reg};
        end
    end

    // control state, pose and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            pose_x_reg  <= '0;
            pose_y_reg  <= '0;
            heading_reg <= '0;
            mpt_reg     <= MPT_RESET;
            iwb_reg     <= IWB_RESET;
            thr_reg     <= THR_RESET;
        end else begin
            state_reg <= state_next;
            if (out_load)      m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            if (state_reg == ST_POSE) begin
                pose_x_reg  <= sat_x;
                pose_y_reg  <= sat_y;
                heading_reg <= heading_reg + dth_reg;
            end
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_MPT: mpt_reg <= cfg_wdata;
                    CFG_IWB: iwb_reg <= cfg_wdata;
                    CFG_THR: thr_reg <= cfg_wdata[15:0];
                    default: thr_reg <= thr_reg;
                endcase
            end
        end
    end

endmodule

@@ design/quadrature_ackermann_odometry.sv @@
// Quadrature encoder and Ackermann dead-reckoning odometry.
// Input stream: s_tuser selects the beat kind (0 encoder sample, 1 odometry
// tick). Samples carry the A/B channel levels and are absorbed by the front
// end at one beat per cycle; they produce no output. Ticks carry steering
// angle and elapsed microseconds and yield one pose beat on m_*.
// A tick snapshots the pulse count when accepted and enters a two-deep
// queue; the back end works one tick at a time through a shared 35x35
// multiplier, a radix-2 divider and an iterative CORDIC for sine/cosine
// pairs. An arc update needs one more CORDIC run and two more divisions
// than a straight update; the yaw-rate division is skipped when the steering
// cosine is zero. The divider takes the bulk of a tick's processing time.
// Samples keep flowing while ticks are processed unless the queue is full;
// then s_tready drops. Result beats sit in an output register; a stalled
// receiver holds the back end at its final step and, once the queue fills,
// the input side. Reset (synchronous, active low) clears the pulse counters,
// pose, queue and output valid, and loads the default configuration. cfg_we
// writes the register at cfg_addr in the same cycle (0 travel per count, 1
// inverse wheelbase, 2 turn threshold); write only while no tick is in flight.
module quadrature_ackermann_odometry (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // enc_a, enc_b, steer angle, tick_interval_us, zero pad
    input  logic [qao_pkg::IN_W-1:0]   s_tdata,
    // mode
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // x_pos, y_pos, heading, quat_z, quat_w, linear_velocity, angular_velocity
    output logic [qao_pkg::OUT_W-1:0]  m_tdata,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_addr,
    input  logic [31:0]                cfg_wdata
);
    import qao_pkg::*;

    logic      q_full, q_push, q_pop, q_avail;
    tick_job_t job_in, job_out;

    qao_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .mode             (s_tuser),
        .enc_a            (s_tdata[0]),
        .enc_b            (s_tdata[1]),
        .steer_in         ($signed(s_tdata[17:2])),
        .tick_interval_us (s_tdata[37:18]),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_job            (job_in)
    );

    qao_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (job_in),
        .full    (q_full),
        .pop     (q_pop),
        .avail   (q_avail),
        .dout    (job_out)
    );

    qao_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_avail   (q_avail),
        .q_job     (job_out),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ design/qao_checker.sv @@
module qao_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [qao_pkg::OUT_W-1:0] m_tdata
);
    import qao_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // half-angle cosine never drops below minus one
    a_qw_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[159:128]) >= -32'sd1073741824))
        else $error("quat_w below range");

    // quaternion components stay within unit range
    a_qz_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[127:96]) <= 32'sd1073741824) &&
                     ($signed(m_tdata[127:96]) >= -32'sd1073741824) &&
                     ($signed(m_tdata[159:128]) <= 32'sd1073741824))
        else $error("quaternion out of range");

endmodule

bind quadrature_ackermann_odometry qao_checker u_qao_checker (.*);

@@ verif/quadrature_ackermann_odometry_tb.sv @@
`timescale 1ns / 1ps

module quadrature_ackermann_odometry_tb;
    import qao_pkg::*;

    localparam logic [1:0] CFG_NONE = 2'd3;   // index past the register list
    localparam bit MODE_SAMPLE = 1'b0;
    localparam bit MODE_TICK   = 1'b1;
    localparam int TICK_LATENCY = 600;

    typedef struct packed {
        logic [31:0] x_pos;
        logic [31:0] y_pos;
        logic [31:0] heading;
        logic [31:0] quat_z;
        logic [31:0] quat_w;
        logic [31:0] lin_vel;
        logic [31:0] ang_vel;
    } pose_beat_t;

    // binary-angle arctangent of 2^-i
    localparam logic [31:0] ATAN_BA [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_addr = '0;
    logic [31:0]         cfg_wdata = '0;

    // predictor state
    logic [31:0] mpt_q, iwb_q;
    logic [15:0] thr_q;
    logic [31:0] pulse_total_q, pulse_snap_q;
    bit          level_a_q, primed_q;
    logic [31:0] pose_x_q, pose_y_q, heading_q;

    pose_beat_t pose_expected[$];
    int         mismatches = 0;
    int         src_idle_pct = 0;
    int         rcv_stall_pct = 0;
    int         rcv_hold_cycles = 0;
    int         enc_phase = 0;
    int         beats_sent = 0;

    quadrature_ackermann_odometry DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                    output longint s);
        bit flip;
        logic [31:0] a;
        longint x, y, z, nx, ta;
        flip = 1'b0;
        a = ang;
        if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
            a = a - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
            ta = longint'(ATAN_BA[i]);
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ta;
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ta;
            end
            x = nx;
        end
        if (x > 64'sd1073741824) x = 1073741824;
        if (x < -64'sd1073741824) x = -1073741824;
        if (y > 64'sd1073741824) y = 1073741824;
        if (y < -64'sd1073741824) y = -1073741824;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // v * diff / (|w| * 2^14), rounded on magnitudes
    function automatic longint arc_step(input logic [63:0] vmag, input bit vneg,
                                        input longint diff, input logic [63:0] wmag,
                                        input bit wneg);
        logic [63:0] dmag, den, q;
        dmag = diff < 0 ? 64'(-diff) : 64'(diff);
        den = wmag << 14;
        q = (vmag * dmag + den / 2) / den;
        return (vneg ^ (diff < 0) ^ wneg) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] sat_pos(input logic [31:0] p, input longint d);
        longint r;
        r = longint'($signed(p)) + d;
        if (r > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (r < -64'sd2147483648) return 32'h8000_0000;
        return r[31:0];
    endfunction

    function automatic void count_edge(input bit a, input bit b);
        if (primed_q && a != level_a_q)
            pulse_total_q = (a != b) ? pulse_total_q + 1 : pulse_total_q - 1;
        level_a_q = a;
        primed_q = 1'b1;
    endfunction

    function automatic pose_beat_t advance_pose(input logic [15:0] steer_raw,
                                                input logic [19:0] us_raw);
        pose_beat_t  r;
        logic [31:0] raw, am, sa, dth;
        logic [63:0] dmag, travel, us, vmag, smag, t, num, wmag, cm, wd;
        logic [127:0] prod;
        bit          neg, wneg;
        longint      dist_s, v_s, w_s, sc, ss, c0, s0, c1, s1, qz, qw, dx, dy;
        logic signed [15:0] steer;

        raw = pulse_total_q - pulse_snap_q;
        pulse_snap_q = pulse_total_q;
        neg = raw[31];
        dmag = neg ? 64'(32'(-raw)) : 64'(raw);
        if (dmag > 64'h7FFF_FFFF) dmag = 64'h7FFF_FFFF;
        travel = (dmag * 64'(mpt_q) + 64'd32768) >> 16;
        if (travel > 64'h7FFF_FFFF) travel = 64'h7FFF_FFFF;
        if (travel == 0) neg = 1'b0;
        dist_s = neg ? -longint'(travel) : longint'(travel);

        us = (us_raw == 0) ? 64'd1 : 64'(us_raw);
        vmag = (travel * 64'd1000000 + us / 2) / us;
        if (vmag > 64'h7FFF_FFFF) vmag = 64'h7FFF_FFFF;
        v_s = neg ? -longint'(vmag) : longint'(vmag);

        // steering to binary angle
        steer = $signed(steer_raw);
        smag = steer < 0 ? 64'(-longint'(steer)) : 64'(longint'(steer));
        am = 32'((smag * 64'(STEER_TO_ANGLE) + 64'd32768) >> 16);
        sa = steer < 0 ? -am : am;
        sin_cos(sa, sc, ss);

        // yaw rate = v * tan(steer) / L
        t = (vmag * 64'(iwb_q) + 64'd8388608) >> 24;
        if (t > 64'h1_FFFF_FFFF) t = 64'h1_FFFF_FFFF;
        num = t * (ss < 0 ? 64'(-ss) : 64'(ss));
        if (sc == 0) begin
            wmag = (num == 0) ? 64'd0 : 64'h7FFF_FFFF;
        end else begin
            cm = sc < 0 ? 64'(-sc) : 64'(sc);
            wmag = (num + cm / 2) / cm;
            if (wmag > 64'h7FFF_FFFF) wmag = 64'h7FFF_FFFF;
        end
        wneg = (wmag != 0) && (neg ^ (ss < 0) ^ (sc < 0));
        w_s = wneg ? -longint'(wmag) : longint'(wmag);

        wd = wmag * us;
        prod = 128'(wd) * 128'(RATE_TO_ANGLE);
        dth = prod[71:40];
        if (wneg) dth = -dth;

        // pose update: arc or straight line
        sin_cos(heading_q, c0, s0);
        if (wmag > 64'(thr_q)) begin
            sin_cos(heading_q + dth, c1, s1);
            dx = arc_step(vmag, neg, s1 - s0, wmag, wneg);
            dy = -arc_step(vmag, neg, c1 - c0, wmag, wneg);
        end else begin
            dx = (dist_s * c0 + (64'sd1 <<< 29)) >>> 30;
            dy = (dist_s * s0 + (64'sd1 <<< 29)) >>> 30;
        end
        pose_x_q = sat_pos(pose_x_q, dx);
        pose_y_q = sat_pos(pose_y_q, dy);
        heading_q = heading_q + dth;
        sin_cos(heading_q >> 1, qw, qz);

        r.x_pos = pose_x_q;
        r.y_pos = pose_y_q;
        r.heading = heading_q;
        r.quat_z = qz[31:0];
        r.quat_w = qw[31:0];
        r.lin_vel = v_s[31:0];
        r.ang_vel = w_s[31:0];
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // called right after a rising edge; returns at the edge that takes the beat
    task automatic send_beat(input bit mode, input bit a, input bit b,
                             input logic [15:0] steer, input logic [19:0] us);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {2'b00, us, steer, b, a};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        beats_sent++;
        if (mode == MODE_SAMPLE) count_edge(a, b);
        else pose_expected.push_back(advance_pose(steer, us));
    endtask

    task automatic send_sample(input bit a, input bit b);
        send_beat(MODE_SAMPLE, a, b, 16'($urandom), 20'($urandom));
    endtask

    task automatic send_tick(input logic [15:0] steer, input logic [19:0] us);
        send_beat(MODE_TICK, 1'($urandom), 1'($urandom), steer, us);
    endtask

    // clean quadrature step, forward or backward
    task automatic step_encoder(input bit fwd);
        enc_phase = fwd ? (enc_phase + 1) % 4 : (enc_phase + 3) % 4;
        case (enc_phase)
            0: send_sample(1'b0, 1'b0);
            1: send_sample(1'b1, 1'b0);
            2: send_sample(1'b1, 1'b1);
            default: send_sample(1'b0, 1'b1);
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pose_expected.size() == 0);
        @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MPT: mpt_q = val;
            CFG_IWB: iwb_q = val;
            CFG_THR: thr_q = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] mpt, input logic [31:0] iwb,
                            input logic [15:0] thr);
        write_reg(CFG_MPT, mpt);
        write_reg(CFG_IWB, iwb);
        write_reg(CFG_THR, {16'h0, thr});
    endtask

    // ---------------- receiver ----------------

    always @(posedge aclk) begin
        if (rcv_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rcv_hold_cycles <= rcv_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // a beat seen here with both high transfers at the next rising edge
    always @(negedge aclk) begin
        pose_beat_t exp_b, act_b;
        if (aresetn && m_tvalid && m_tready) begin
            act_b = pose_beat_t'({m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
                                  m_tdata[127:96], m_tdata[159:128],
                                  m_tdata[191:160], m_tdata[223:192]});
            if (pose_expected.size() == 0) begin
                $error("unexpected pose beat %h", m_tdata);
                mismatches++;
            end else begin
                exp_b = pose_expected.pop_front();
                check_field("x_pos", exp_b.x_pos, act_b.x_pos);
                check_field("y_pos", exp_b.y_pos, act_b.y_pos);
                check_field("heading", exp_b.heading, act_b.heading);
                check_field("quat_z", exp_b.quat_z, act_b.quat_z);
                check_field("quat_w", exp_b.quat_w, act_b.quat_w);
                check_field("linear_velocity", exp_b.lin_vel, act_b.lin_vel);
                check_field("angular_velocity", exp_b.ang_vel, act_b.ang_vel);
            end
        end
    end

    // ---------------- tests ----------------

    // long run of counts at maximum travel per count, straight ahead at heading zero
    task automatic test_long_travel();
        write_reg(CFG_MPT, 32'hFFFF_FFFF);
        send_sample(1'b0, 1'b1);             // priming only
        for (int i = 0; i < 200; i++) send_sample(i[0] ? 1'b0 : 1'b1, i[0]);
        send_tick(16'h0000, 20'd1000000);
        for (int i = 0; i < 4; i++) send_sample(i[0] ? 1'b0 : 1'b1, i[0]);
        send_tick(16'h0000, 20'd1000000);
        wait_idle();
        write_reg(CFG_MPT, MPT_RESET);
    endtask

    task automatic test_encoder_and_ticks();
        // count both ways, repeats of A that do not count
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        send_tick(16'h0000, 20'd0);            // zero interval
        for (int i = 0; i < 6; i++) step_encoder(1'b0);
        send_tick(16'h7FFF, 20'hFFFFF);        // steering and interval maxima
        for (int i = 0; i < 6; i++) step_encoder(1'b1);
        send_tick(16'h8000, 20'd1);
        send_tick(16'd25735, 20'd20000);       // near a right-angle steer
        step_encoder(1'b1);
        send_tick(16'd25736, 20'd20000);
        step_encoder(1'b1);
        send_tick(16'd25737, 20'd20000);
        step_encoder(1'b0);
        send_tick(-16'sd25736, 20'd3);
        wait_idle();
        write_reg(CFG_NONE, 32'hFFFF_FFFF);   // ignored index
    endtask

    // receiver holds off while ticks keep coming, then sender waits for drain
    task automatic test_backpressure();
        rcv_hold_cycles = 4000;
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 5; i++) step_encoder(1'b1);
            send_tick(16'($urandom_range(0, 12000)), 20'd20000);
        end
        wait_idle();
    endtask

    task automatic random_traffic(input int n_beats);
        int stop_at;
        int burst;
        bit fwd;
        logic [15:0] steer;
        logic [19:0] us;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            burst = $urandom_range(0, 30);
            fwd = 1'($urandom_range(0, 1));
            for (int i = 0; i < burst; i++) begin
                if ($urandom_range(99) < 10) send_sample(1'($urandom), 1'($urandom));
                else step_encoder($urandom_range(99) < 85 ? fwd : !fwd);
            end
            case ($urandom_range(0, 3))
                0: steer = 16'($urandom);
                default: steer = 16'($signed($urandom_range(0, 12000)) - 6000);
            endcase
            case ($urandom_range(0, 4))
                0: us = 20'($urandom_range(0, 1048575));
                1: us = 20'($urandom_range(0, 100));
                default: us = 20'($urandom_range(15000, 25000));
            endcase
            send_tick(steer, us);
        end
        wait_idle();
    endtask

    task automatic test_random_phases();
        src_idle_pct = 0;  rcv_stall_pct = 0;
        random_traffic(250);
        set_regs(32'h0, 32'h0, 16'h0);
        src_idle_pct = 55; rcv_stall_pct = 0;
        random_traffic(250);
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        src_idle_pct = 0;  rcv_stall_pct = 55;
        random_traffic(250);
        set_regs($urandom_range(200000, 50000000), $urandom,
                 16'($urandom_range(0, 2000)));
        src_idle_pct = 30; rcv_stall_pct = 30;
        random_traffic(250);
    endtask

    initial begin
        mpt_q = MPT_RESET;
        iwb_q = IWB_RESET;
        thr_q = THR_RESET;
        pulse_total_q = '0;
        pulse_snap_q = '0;
        level_a_q = 1'b0;
        primed_q = 1'b0;
        pose_x_q = '0;
        pose_y_q = '0;
        heading_q = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_long_travel();
        test_encoder_and_ticks();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (TICK_LATENCY) @(posedge aclk);
        if (mismatches == 0 && pose_expected.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
